// File: src/hrhp_pkg.sv
// Shared types, codes and match strings for the HTTP request head parser.
package hrhp_pkg;

  localparam int NUM_METHODS = 3;
  localparam int NUM_NAMES   = 8;
  localparam int VERSION_LEN = 8;

  // Result kinds
  localparam logic [1:0] KIND_URI      = 2'd0;
  localparam logic [1:0] KIND_VALUE    = 2'd1;
  localparam logic [1:0] KIND_REQ_END  = 2'd2;
  localparam logic [1:0] KIND_HDR_END  = 2'd3;

  // Method codes
  localparam logic [1:0] METH_NONE   = 2'd0;
  localparam logic [1:0] METH_GET    = 2'd1;
  localparam logic [1:0] METH_POST   = 2'd2;
  localparam logic [1:0] METH_DELETE = 2'd3;

  localparam logic [3:0] HDR_NONE = 4'd0;

  // Error codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_METHOD     = 3'd1;
  localparam logic [2:0] ERR_EMPTY_URI  = 3'd2;
  localparam logic [2:0] ERR_VERSION    = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd5;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Strings are right-justified: last character in the low byte
  localparam logic [47:0] METHOD_STR [NUM_METHODS] = '{"GET", "POST", "DELETE"};
  localparam int METHOD_LEN [NUM_METHODS] = '{3, 4, 6};

  localparam logic [63:0] VERSION_STR = "HTTP/1.1";

  localparam logic [127:0] NAME_STR [NUM_NAMES] = '{
    "Accept", "Accept-Charset", "Connection", "Content-Length",
    "Content-Type", "Content-Encoding", "Host", "From"
  };
  localparam int NAME_LEN [NUM_NAMES] = '{6, 14, 10, 14, 12, 16, 4, 4};

  typedef struct packed {
    logic       som;
    logic       eom;
    logic [7:0] data_byte;
  } hrhp_item_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic [3:0] header_code;
    logic [1:0] method_code;
    logic [7:0] out_byte;
    logic [1:0] kind;
  } hrhp_result_t;

  function automatic logic [7:0] method_char(input int idx, input logic [2:0] pos);
    logic [47:0] w;
    w = '0;
    if (int'(pos) < METHOD_LEN[idx]) begin
      w = METHOD_STR[idx] >> (8 * (METHOD_LEN[idx] - 1 - int'(pos)));
    end
    return w[7:0];
  endfunction

  function automatic logic [7:0] name_char(input int idx, input logic [3:0] pos);
    logic [127:0] w;
    w = '0;
    if (int'(pos) < NAME_LEN[idx]) begin
      w = NAME_STR[idx] >> (8 * (NAME_LEN[idx] - 1 - int'(pos)));
    end
    return w[7:0];
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] pos);
    return VERSION_STR[(7 - int'(pos)) * 8 +: 8];
  endfunction

  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] e);
    return (cur != ERR_OK) ? cur : e;
  endfunction

endpackage

// File: src/hrhp_parser.sv
// Parser state registers and the per-byte update and result logic.
module hrhp_parser import hrhp_pkg::*; #(
  parameter int METHOD_MAX  = 8,
  parameter int URI_MAX     = 256,
  parameter int VERSION_MAX = 16,
  parameter int NAME_MAX    = 32,
  parameter int VALUE_MAX   = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  hrhp_item_t   item,
  output logic         res_valid,
  output hrhp_result_t res
);

  localparam int MAX_A = (METHOD_MAX > VERSION_MAX) ? METHOD_MAX : VERSION_MAX;
  localparam int MAX_B = (NAME_MAX > VALUE_MAX) ? NAME_MAX : VALUE_MAX;
  localparam int TPW   = $clog2((MAX_A > MAX_B) ? MAX_A : MAX_B);
  localparam int UW    = $clog2(URI_MAX);

  typedef struct packed {
    logic                 req_done;
    logic                 halted;
    logic [1:0]           space_cnt;
    logic                 colon_seen;
    logic [TPW-1:0]       tok_pos;
    logic [2:0]           meth_cand;
    logic                 ver_match;
    logic [NUM_NAMES-1:0] name_cand;
    logic [UW-1:0]        uri_len;
    logic [2:0]           line_err;
    logic [3:0]           hdr;
  } state_t;

  localparam state_t STATE_RST = '{
    req_done:   1'b0,
    halted:     1'b0,
    space_cnt:  2'd0,
    colon_seen: 1'b0,
    tok_pos:    '0,
    meth_cand:  3'b111,
    ver_match:  1'b1,
    name_cand:  '1,
    uri_len:    '0,
    line_err:   ERR_OK,
    hdr:        HDR_NONE
  };

  state_t state_r, state_nxt;

  function automatic logic [2:0] finish_cands(input logic [2:0] c, input logic [TPW-1:0] tp);
    logic [2:0] m;
    m = '0;
    for (int i = 0; i < NUM_METHODS; i++) begin
      if (c[i] && int'(tp) == METHOD_LEN[i]) m[i] = 1'b1;
    end
    return m;
  endfunction

  always_comb begin
    state_t     s;
    logic [7:0] b;
    logic       term;
    logic [1:0] mc;
    s         = state_r;
    b         = item.data_byte;
    term      = (b == CHAR_CR) || (b == CHAR_LF);
    mc        = METH_NONE;
    res_valid = 1'b0;
    res       = '0;

    if (item.som) s = STATE_RST;

    if (!s.halted) begin
      if (!term) begin
        if (!s.req_done) begin
          unique case (s.space_cnt)
            2'd0: begin
              if (b == CHAR_SPACE) begin
                s.meth_cand = finish_cands(s.meth_cand, s.tok_pos);
                if (s.meth_cand == 3'b000) s.line_err = first_err(s.line_err, ERR_METHOD);
                s.space_cnt = 2'd1;
              end else begin
                for (int i = 0; i < NUM_METHODS; i++) begin
                  if (int'(s.tok_pos) >= METHOD_LEN[i] ||
                      b != method_char(i, s.tok_pos[2:0])) s.meth_cand[i] = 1'b0;
                end
                if (int'(s.tok_pos) >= METHOD_MAX - 1) begin
                  s.line_err = first_err(s.line_err, ERR_TOO_LONG);
                end else begin
                  s.tok_pos = s.tok_pos + 1'b1;
                end
              end
            end
            2'd1: begin
              if (b == CHAR_SPACE) begin
                if (s.uri_len == '0) s.line_err = first_err(s.line_err, ERR_EMPTY_URI);
                s.space_cnt = 2'd2;
                s.tok_pos   = '0;
              end else if (int'(s.uri_len) >= URI_MAX - 1) begin
                s.line_err = first_err(s.line_err, ERR_TOO_LONG);
              end else begin
                s.uri_len = s.uri_len + 1'b1;
                if (s.line_err == ERR_OK) begin
                  res_valid    = 1'b1;
                  res.kind     = KIND_URI;
                  res.out_byte = b;
                end
              end
            end
            2'd2: begin
              if (b == CHAR_SPACE) begin
                s.line_err  = first_err(s.line_err, ERR_VERSION);
                s.space_cnt = 2'd3;
              end else begin
                if (int'(s.tok_pos) >= VERSION_LEN || b != version_char(s.tok_pos[2:0]))
                  s.ver_match = 1'b0;
                if (int'(s.tok_pos) >= VERSION_MAX - 1) begin
                  s.line_err = first_err(s.line_err, ERR_TOO_LONG);
                end else begin
                  s.tok_pos = s.tok_pos + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end else if (!s.colon_seen) begin
          if (b == CHAR_COLON) begin
            for (int i = 0; i < NUM_NAMES; i++) begin
              if (s.hdr == HDR_NONE && s.name_cand[i] && int'(s.tok_pos) == NAME_LEN[i])
                s.hdr = 4'(i + 1);
            end
            if (s.hdr == HDR_NONE) s.line_err = first_err(s.line_err, ERR_UNKNOWN);
            s.colon_seen = 1'b1;
            s.tok_pos    = '0;
          end else begin
            for (int i = 0; i < NUM_NAMES; i++) begin
              if (int'(s.tok_pos) >= NAME_LEN[i] || b != name_char(i, s.tok_pos[3:0]))
                s.name_cand[i] = 1'b0;
            end
            if (int'(s.tok_pos) >= NAME_MAX - 1) begin
              s.line_err = first_err(s.line_err, ERR_TOO_LONG);
            end else begin
              s.tok_pos = s.tok_pos + 1'b1;
            end
          end
        end else if (int'(s.tok_pos) >= VALUE_MAX - 1) begin
          s.line_err = first_err(s.line_err, ERR_TOO_LONG);
        end else begin
          s.tok_pos = s.tok_pos + 1'b1;
          if (s.line_err == ERR_OK) begin
            res_valid       = 1'b1;
            res.kind        = KIND_VALUE;
            res.out_byte    = b;
            res.header_code = s.hdr;
          end
        end
        if (item.eom) begin
          res_valid = 1'b0;
          res       = '0;
        end
      end

      // Line end: terminator, or end of message on an open line
      if ((term || item.eom) &&
          (s.space_cnt != 2'd0 || s.colon_seen || s.tok_pos != '0 ||
           s.uri_len != '0 || s.line_err != ERR_OK)) begin
        res = '0;
        if (!s.req_done) begin
          unique case (s.space_cnt)
            2'd0: begin
              s.meth_cand = finish_cands(s.meth_cand, s.tok_pos);
              if (s.meth_cand == 3'b000) s.line_err = first_err(s.line_err, ERR_METHOD);
              s.line_err = first_err(s.line_err, ERR_EMPTY_URI);
            end
            2'd1: begin
              s.line_err = first_err(s.line_err,
                                     (s.uri_len == '0) ? ERR_EMPTY_URI : ERR_VERSION);
            end
            2'd2: begin
              if (!(s.ver_match && int'(s.tok_pos) == VERSION_LEN))
                s.line_err = first_err(s.line_err, ERR_VERSION);
            end
            default: ;
          endcase
          if (s.meth_cand[0])      mc = METH_GET;
          else if (s.meth_cand[1]) mc = METH_POST;
          else if (s.meth_cand[2]) mc = METH_DELETE;
          res_valid       = 1'b1;
          res.kind        = KIND_REQ_END;
          res.method_code = mc;
          res.error_code  = s.line_err;
          s.req_done      = 1'b1;
        end else begin
          if (!s.colon_seen) s.line_err = first_err(s.line_err, ERR_UNKNOWN);
          res_valid       = 1'b1;
          res.kind        = KIND_HDR_END;
          res.header_code = s.hdr;
          res.error_code  = s.line_err;
        end
        if (s.line_err != ERR_OK) s.halted = 1'b1;
        s.space_cnt  = STATE_RST.space_cnt;
        s.colon_seen = STATE_RST.colon_seen;
        s.tok_pos    = STATE_RST.tok_pos;
        s.uri_len    = STATE_RST.uri_len;
        s.meth_cand  = STATE_RST.meth_cand;
        s.ver_match  = STATE_RST.ver_match;
        s.name_cand  = STATE_RST.name_cand;
        s.line_err   = STATE_RST.line_err;
        s.hdr        = STATE_RST.hdr;
      end

      if (item.eom) s.halted = 1'b1;
    end

    state_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/http_request_head_parser.sv
// Top level: input register, parser, result register and stream handshakes.
// A result passes from its input transfer through the input register, then the result register.
// Throughput: 1 byte per cycle while the result register is not stalled; the parser state updates once per byte.
// A stalled result register holds its transfer and backs up the input register.
// Reset: synchronous, active low; empties both register stages and clears parser state.
module http_request_head_parser import hrhp_pkg::*; #(
  parameter int METHOD_MAX  = 8,
  parameter int URI_MAX     = 256,
  parameter int VERSION_MAX = 16,
  parameter int NAME_MAX    = 32,
  parameter int VALUE_MAX   = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_message
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [9:8] method_code,
                                  // [13:10] header_code, [16:14] error_code, rest zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic         in_valid_r, in_valid_nxt;
  hrhp_item_t   in_item_r;
  logic         adv;
  logic         res_valid;
  hrhp_result_t res;
  logic         out_valid_r, out_valid_nxt;
  hrhp_result_t out_res_r;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (adv) in_valid_nxt = 1'b0;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    out_valid_nxt = adv ? res_valid : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= '{som: in_tuser, eom: in_tlast, data_byte: in_tdata};
    end
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  hrhp_parser #(
    .METHOD_MAX  (METHOD_MAX),
    .URI_MAX     (URI_MAX),
    .VERSION_MAX (VERSION_MAX),
    .NAME_MAX    (NAME_MAX),
    .VALUE_MAX   (VALUE_MAX)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.error_code, out_res_r.header_code,
                       out_res_r.method_code, out_res_r.out_byte};

  // Content transfers carry no method or error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_URI || out_res_r.kind == KIND_VALUE)
    |-> out_res_r.error_code == ERR_OK && out_res_r.method_code == METH_NONE)
    else $error("content transfer with method or error set");

  // Line ends carry no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_REQ_END || out_res_r.kind == KIND_HDR_END)
    |-> out_res_r.out_byte == 8'd0)
    else $error("line end transfer with a byte");

  // Header code only on header kinds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_URI || out_res_r.kind == KIND_REQ_END)
    |-> out_res_r.header_code == HDR_NONE)
    else $error("header code on request line transfer");

  // An accepted byte is held in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_valid_r)
    else $error("input transfer lost");

  // A waiting result is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !adv)
    else $error("parser advanced over a stalled result");

endmodule

// File: tb/sv/tb_http_request_head_parser.sv
// Self-checking testbench for the HTTP request head parser: directed table, then random messages.
module tb_http_request_head_parser;
  import hrhp_pkg::*;

  localparam int METHOD_MAX   = 8;
  localparam int URI_MAX      = 256;
  localparam int VERSION_MAX  = 16;
  localparam int NAME_MAX     = 32;
  localparam int VALUE_MAX    = 256;
  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int TIMEOUT      = 1600000;
  localparam int DIR_ROWS     = 15;

  typedef struct packed {
    logic [7:0] b;
    logic       som;
    logic       eom;
    logic       pinned;
    logic [1:0] kind;
    logic [7:0] ob;
    logic [1:0] meth;
    logic [3:0] hdr;
    logic [2:0] err;
  } dir_row_t;

  typedef struct packed {
    hrhp_item_t   it;
    logic         pinned;
    logic         hold_off;
    hrhp_result_t want;
  } stim_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

  // byte, som, eom, pinned, kind, out_byte, method, header, error
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h00,      1'b1, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_LF,    1'b0, 1'b0, 1'b1, KIND_REQ_END, 8'h00, METH_NONE, HDR_NONE, ERR_METHOD},
    '{"x",        1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{"G",        1'b1, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{"E",        1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{"T",        1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{"/",        1'b0, 1'b0, 1'b1, KIND_URI,     "/",   METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{"H",        1'b0, 1'b1, 1'b1, KIND_REQ_END, 8'h00, METH_GET,  HDR_NONE, ERR_VERSION},
    '{8'hFF,      1'b1, 1'b1, 1'b1, KIND_REQ_END, 8'h00, METH_NONE, HDR_NONE, ERR_METHOD},
    '{CHAR_CR,    1'b1, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_LF,    1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_URI,     8'h00, METH_NONE, HDR_NONE, ERR_OK},
    '{CHAR_CR,    1'b0, 1'b0, 1'b1, KIND_REQ_END, 8'h00, METH_NONE, HDR_NONE, ERR_METHOD}
  };

  string meth_txt [NUM_METHODS] = '{"GET", "POST", "DELETE"};
  string name_txt [NUM_NAMES] = '{"Accept", "Accept-Charset", "Connection", "Content-Length",
                                  "Content-Type", "Content-Encoding", "Host", "From"};
  string ver_txt = "HTTP/1.1";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  stim_t        stim [$];
  logic [7:0]   msg_bytes [$];
  hrhp_result_t pending_results [$];
  int           fail_count = 0;

  // parser state as the predictor sees it
  bit         line_done, halted, colon;
  logic [1:0] spaces;
  int         tok_pos, uri_len;
  logic [2:0] meth_cand;
  bit         ver_ok;
  logic [7:0] name_cand;
  logic [2:0] line_err;
  logic [3:0] hdr;

  always #2 clk = ~clk;

  http_request_head_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic void clear_line();
    spaces = 2'd0;
    colon = 1'b0;
    tok_pos = 0;
    uri_len = 0;
    meth_cand = 3'b111;
    ver_ok = 1'b1;
    name_cand = 8'hFF;
    line_err = ERR_OK;
    hdr = HDR_NONE;
  endfunction

  function automatic void note_err(logic [2:0] e);
    if (line_err == ERR_OK) line_err = e;
  endfunction

  function automatic bit bump_tok(int lim);
    if (tok_pos >= lim - 1) begin
      note_err(ERR_TOO_LONG);
      return 1'b0;
    end
    tok_pos++;
    return 1'b1;
  endfunction

  function automatic void close_method();
    logic [2:0] mask;
    mask = '0;
    for (int i = 0; i < NUM_METHODS; i++)
      if (meth_cand[i] && tok_pos == meth_txt[i].len()) mask[i] = 1'b1;
    meth_cand = mask;
    if (mask == '0) note_err(ERR_METHOD);
  endfunction

  function automatic bit request_byte(logic [7:0] b, output hrhp_result_t r);
    r = '0;
    case (spaces)
      2'd0: begin
        if (b == CHAR_SPACE) begin
          close_method();
          spaces = 2'd1;
          return 1'b0;
        end
        for (int i = 0; i < NUM_METHODS; i++)
          if (tok_pos >= meth_txt[i].len() || b != meth_txt[i][tok_pos]) meth_cand[i] = 1'b0;
        void'(bump_tok(METHOD_MAX));
      end
      2'd1: begin
        if (b == CHAR_SPACE) begin
          if (uri_len == 0) note_err(ERR_EMPTY_URI);
          spaces = 2'd2;
          tok_pos = 0;
          return 1'b0;
        end
        if (uri_len >= URI_MAX - 1) begin
          note_err(ERR_TOO_LONG);
        end else begin
          uri_len++;
          if (line_err == ERR_OK) begin
            r.kind = KIND_URI;
            r.out_byte = b;
            return 1'b1;
          end
        end
      end
      2'd2: begin
        if (b == CHAR_SPACE) begin
          note_err(ERR_VERSION);
          spaces = 2'd3;
          return 1'b0;
        end
        if (tok_pos >= VERSION_LEN || b != ver_txt[tok_pos]) ver_ok = 1'b0;
        void'(bump_tok(VERSION_MAX));
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit header_byte(logic [7:0] b, output hrhp_result_t r);
    r = '0;
    if (!colon) begin
      if (b == CHAR_COLON) begin
        for (int i = 0; i < NUM_NAMES; i++)
          if (hdr == HDR_NONE && name_cand[i] && tok_pos == name_txt[i].len()) hdr = 4'(i + 1);
        if (hdr == HDR_NONE) note_err(ERR_UNKNOWN);
        colon = 1'b1;
        tok_pos = 0;
        return 1'b0;
      end
      for (int i = 0; i < NUM_NAMES; i++)
        if (tok_pos >= name_txt[i].len() || b != name_txt[i][tok_pos]) name_cand[i] = 1'b0;
      void'(bump_tok(NAME_MAX));
      return 1'b0;
    end
    if (bump_tok(VALUE_MAX) && line_err == ERR_OK) begin
      r.kind = KIND_VALUE;
      r.out_byte = b;
      r.header_code = hdr;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit close_line(output hrhp_result_t r);
    r = '0;
    if (!line_done) begin
      case (spaces)
        2'd0: begin
          close_method();
          note_err(ERR_EMPTY_URI);
        end
        2'd1: note_err((uri_len == 0) ? ERR_EMPTY_URI : ERR_VERSION);
        2'd2: if (!(ver_ok && tok_pos == VERSION_LEN)) note_err(ERR_VERSION);
        default: ;
      endcase
      r.kind = KIND_REQ_END;
      r.method_code = meth_cand[0] ? METH_GET : meth_cand[1] ? METH_POST :
                      meth_cand[2] ? METH_DELETE : METH_NONE;
      r.error_code = line_err;
      line_done = 1'b1;
    end else begin
      if (!colon) note_err(ERR_UNKNOWN);
      r.kind = KIND_HDR_END;
      r.header_code = hdr;
      r.error_code = line_err;
    end
    if (line_err != ERR_OK) halted = 1'b1;
    clear_line();
    return 1'b1;
  endfunction

  function automatic bit parse_byte(hrhp_item_t it, output hrhp_result_t r);
    bit term, got;
    got = 1'b0;
    r = '0;
    term = (it.data_byte == CHAR_CR || it.data_byte == CHAR_LF);
    if (it.som) begin
      line_done = 1'b0;
      halted = 1'b0;
      clear_line();
    end
    if (halted) return 1'b0;
    if (!term) begin
      got = line_done ? header_byte(it.data_byte, r) : request_byte(it.data_byte, r);
      if (it.eom) got = 1'b0;
    end
    if ((term || it.eom) &&
        (spaces != 2'd0 || colon || tok_pos != 0 || uri_len != 0 || line_err != ERR_OK))
      got = close_line(r);
    if (it.eom) halted = 1'b1;
    return got;
  endfunction

  function automatic logic [7:0] text_char(bit no_space);
    logic [7:0] c;
    do begin
      c = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(33, 126));
    end while (c == CHAR_CR || c == CHAR_LF || (no_space && c == CHAR_SPACE));
    return c;
  endfunction

  function automatic void put_run(int n, bit no_space);
    for (int i = 0; i < n; i++) msg_bytes.push_back(text_char(no_space));
  endfunction

  // mangling swaps one character, truncates, or adds a stray character
  function automatic void put_text(string s, bit mangle);
    int cut, pos;
    cut = s.len();
    pos = $urandom_range(s.len() - 1);
    if (mangle && $urandom_range(1) == 0) cut = pos;
    for (int i = 0; i < cut; i++)
      msg_bytes.push_back((mangle && i == pos) ? text_char(1'b1) : s[i]);
    if (mangle && $urandom_range(3) == 0) msg_bytes.push_back(text_char(1'b1));
  endfunction

  function automatic void put_eol();
    case ($urandom_range(2))
      0: begin
        msg_bytes.push_back(CHAR_CR);
        msg_bytes.push_back(CHAR_LF);
      end
      1: msg_bytes.push_back(CHAR_LF);
      default: msg_bytes.push_back(CHAR_CR);
    endcase
  endfunction

  function automatic void add_message(bit hold_first);
    stim_t s;
    int    n;
    bit    use_eom;
    msg_bytes.delete();
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
        s = '0;
        s.it.data_byte = 8'($urandom_range(255));
        s.it.som = ($urandom_range(7) == 0);
        s.it.eom = ($urandom_range(7) == 0);
        s.hold_off = hold_first && k == 0;
        stim.push_back(s);
      end
      return;
    end
    repeat ($urandom_range(1)) put_eol();
    case ($urandom_range(15))
      0: put_text(meth_txt[$urandom_range(NUM_METHODS - 1)], 1'b1);
      1: put_run($urandom_range(8, 12), 1'b1);
      default: put_text(meth_txt[$urandom_range(NUM_METHODS - 1)], 1'b0);
    endcase
    msg_bytes.push_back(CHAR_SPACE);
    case ($urandom_range(19))
      0: ;
      1: put_run($urandom_range(250, 262), 1'b1);
      default: put_run($urandom_range(1, 12), 1'b1);
    endcase
    msg_bytes.push_back(CHAR_SPACE);
    case ($urandom_range(15))
      0: put_text(ver_txt, 1'b1);
      1: put_run($urandom_range(14, 18), 1'b1);
      2: begin
        put_text(ver_txt, 1'b0);
        msg_bytes.push_back(CHAR_SPACE);
      end
      default: put_text(ver_txt, 1'b0);
    endcase
    put_eol();
    n = $urandom_range(5);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: put_text(name_txt[$urandom_range(NUM_NAMES - 1)], 1'b1);
        1: put_run($urandom_range(30, 34), 1'b1);
        default: put_text(name_txt[$urandom_range(NUM_NAMES - 1)], 1'b0);
      endcase
      if ($urandom_range(24) != 0) msg_bytes.push_back(CHAR_COLON);
      if ($urandom_range(1) != 0) msg_bytes.push_back(CHAR_SPACE);
      put_run(($urandom_range(29) == 0) ? $urandom_range(250, 262) : $urandom_range(12), 1'b0);
      put_eol();
    end
    if ($urandom_range(3) != 0) put_eol();
    if ($urandom_range(3) == 0) put_run($urandom_range(1, 10), 1'b0);
    use_eom = ($urandom_range(3) != 0);
    foreach (msg_bytes[k]) begin
      s = '0;
      s.it.data_byte = msg_bytes[k];
      s.it.som = (k == 0);
      s.it.eom = use_eom && k == msg_bytes.size() - 1;
      s.hold_off = hold_first && k == 0;
      stim.push_back(s);
    end
  endfunction

  function automatic void build_stimulus();
    stim_t s;
    foreach (DIR_TAB[i]) begin
      s = '0;
      s.it.data_byte = DIR_TAB[i].b;
      s.it.som = DIR_TAB[i].som;
      s.it.eom = DIR_TAB[i].eom;
      s.pinned = DIR_TAB[i].pinned;
      s.want.kind = DIR_TAB[i].kind;
      s.want.out_byte = DIR_TAB[i].ob;
      s.want.method_code = DIR_TAB[i].meth;
      s.want.header_code = DIR_TAB[i].hdr;
      s.want.error_code = DIR_TAB[i].err;
      stim.push_back(s);
    end
    add_message(1'b1);
    while (stim.size() < DIR_ROWS + RANDOM_ITEMS) add_message($urandom_range(5) == 0);
  endfunction

  initial begin : drive_bytes
    int           idx, burst_left, gap_left;
    bit           holding;
    hrhp_result_t r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    line_done = 1'b0;
    halted = 1'b0;
    clear_line();
    build_stimulus();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idx = 0;
    burst_left = $urandom_range(1, 24);
    gap_left = 0;
    holding = 1'b0;
    while (idx < stim.size()) begin
      @(negedge clk);
      if (!holding) begin
        in_tvalid = 1'b0;
        if (stim[idx].hold_off && pending_results.size() != 0) begin
          // wait for the result stream to empty
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          in_tvalid = 1'b1;
          in_tdata = stim[idx].it.data_byte;
          in_tuser = stim[idx].it.som;
          in_tlast = stim[idx].it.eom;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        if (parse_byte(stim[idx].it, r)) pending_results.push_back(stim[idx].pinned ?
                                                                   stim[idx].want : r);
        else if (stim[idx].pinned) pending_results.push_back(stim[idx].want);
        idx++;
        holding = 1'b0;
      end else begin
        holding = in_tvalid;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin : stall_results
    static int       stretch = 0;
    static rx_mode_t mode = RX_OPEN;
    if (stretch == 0) begin
      mode = rx_mode_t'($urandom_range(2));
      stretch = $urandom_range(4, 60);
    end
    stretch--;
    case (mode)
      RX_OPEN: out_tready = 1'b1;
      RX_CHOPPY: out_tready = ($urandom_range(3) != 0);
      default: out_tready = ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    hrhp_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.out_byte = out_tdata[7:0];
      got.method_code = out_tdata[9:8];
      got.header_code = out_tdata[13:10];
      got.error_code = out_tdata[16:14];
      if (pending_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected transfer: kind %0d byte %02h meth %0d hdr %0d err %0d",
                   got.kind, got.out_byte, got.method_code, got.header_code, got.error_code);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[23:17] !== '0) begin
          if (fail_count < 10)
            $display("mismatch: exp kind %0d byte %02h meth %0d hdr %0d err %0d, got %s%h",
                     want.kind, want.out_byte, want.method_code, want.header_code,
                     want.error_code, "tuser/tdata ", {out_tuser, out_tdata});
          fail_count++;
        end
      end
    end
  end

endmodule

// File: files.f
src/hrhp_pkg.sv
src/hrhp_parser.sv
src/http_request_head_parser.sv
tb/sv/tb_http_request_head_parser.sv
